FILE: hdl/bti_pkg.sv
// ----------------------------------------------------------------------------
// Ballistic table interpolator package
// Field widths, register indexes, pipeline payload types and the divider step.
// ----------------------------------------------------------------------------
package bti_pkg;

	localparam int DIST_W = 16;
	localparam int SPD_W  = 14;
	localparam int ANG_W  = 15;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;
	localparam int REG_W  = 2;
	localparam int CFG_W  = 15;
	localparam int VAL_W  = 16;
	localparam int DIF_W  = VAL_W + 1;
	localparam int NUM_W  = 35;
	localparam int MAG_W  = NUM_W - 1;
	localparam int QUO_W  = 15;
	localparam int IDX_SLOTS = 1 << IDX_W;
	localparam logic [DIST_W-1:0] APPLY_DIST = 16'd500;

	typedef enum logic [REG_W-1:0] {
		REG_ENTRIES  = 2'd0,
		REG_HOOD_MIN = 2'd1,
		REG_HOOD_MAX = 2'd2,
		REG_FALLBACK = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                    direct;
		logic [SPD_W-1:0]        spd;
		logic signed [VAL_W-1:0] ang;
		logic                    flag;
	} ctl_t;

	typedef struct packed {
		logic [MAG_W-1:0]  rem_spd;
		logic [MAG_W-1:0]  rem_ang;
		logic [QUO_W-1:0]  q_spd;
		logic [QUO_W-1:0]  q_ang;
		logic [DIST_W-1:0] den;
		logic              neg_ang;
		ctl_t              ctl;
	} dstage_t;

	// One restoring step: quotient bit b of both the speed and the angle.
	function automatic dstage_t div_step(dstage_t d, int b);
		dstage_t          r;
		logic [MAG_W-1:0] sh;
		r  = d;
		sh = MAG_W'(d.den) << b;
		if (d.rem_spd >= sh) begin
			r.rem_spd  = d.rem_spd - sh;
			r.q_spd[b] = 1'b1;
		end
		if (d.rem_ang >= sh) begin
			r.rem_ang  = d.rem_ang - sh;
			r.q_ang[b] = 1'b1;
		end
		return r;
	endfunction

endpackage

FILE: hdl/ballistic_table_interpolator.sv
// ----------------------------------------------------------------------------
// Ballistic table interpolator
// Piecewise-linear lookup of flywheel speed and hood angle against distance.
// ----------------------------------------------------------------------------
// Write items load one breakpoint and give no result; query items give one
// result each. A query enters every cycle while the pipeline is not held, and
// passes through an interval search stage, subtract, multiply and sum stages,
// fifteen restoring divider stages (one quotient bit each) and the clamp into
// the output register. The whole pipeline holds while a result waits.
module ballistic_table_interpolator import bti_pkg::*; #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic [DIST_W-1:0]       entry_distance,
	input  logic [SPD_W-1:0]        entry_speed,
	input  logic signed [ANG_W-1:0] entry_angle,
	input  logic [DIST_W-1:0]       query_distance,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SPD_W-1:0]        target_speed,
	output logic signed [ANG_W-1:0] target_angle,
	output logic                    apply_flag
);

	localparam int SLOTS = (TABLE_DEPTH < IDX_SLOTS) ? TABLE_DEPTH : IDX_SLOTS;
	localparam int LW    = $clog2(SLOTS);

	logic [CNT_W-1:0]        entries_q;
	logic signed [ANG_W-1:0] hood_min_q;
	logic signed [ANG_W-1:0] hood_max_q;
	logic [SPD_W-1:0]        fallback_q;

	logic [DIST_W-1:0]       dist_q [SLOTS];
	logic [SPD_W-1:0]        spd_q  [SLOTS];
	logic signed [ANG_W-1:0] ang_q  [SLOTS];

	logic adv, in_acc;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q  <= CNT_W'(2);
			hood_min_q <= '0;
			hood_max_q <= ANG_W'(9000);
			fallback_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENTRIES:  entries_q  <= cfg_data[CNT_W-1:0];
				REG_HOOD_MIN: hood_min_q <= $signed(cfg_data[ANG_W-1:0]);
				REG_HOOD_MAX: hood_max_q <= $signed(cfg_data[ANG_W-1:0]);
				REG_FALLBACK: fallback_q <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd && ({1'b0, entry_index} < (IDX_W+1)'(SLOTS))) begin
			dist_q[entry_index[LW-1:0]] <= entry_distance;
			spd_q[entry_index[LW-1:0]]  <= entry_speed;
			ang_q[entry_index[LW-1:0]]  <= entry_angle;
		end
	end

	// Interval search and breakpoint selection.
	ctl_t                    ctl_c;
	logic [DIST_W-1:0]       d0_c, d1_c;
	logic signed [VAL_W-1:0] v0_c, v1_c, a0_c, a1_c;

	always_comb begin
		logic [CNT_W-1:0]        n;
		logic [LW-1:0]           last;
		logic [SLOTS-1:0]        ge, le, lsel;
		logic [SLOTS-2:0]        hit;
		logic                    found, zw;
		logic [DIST_W-1:0]       dl;
		logic [SPD_W-1:0]        sl;
		logic signed [ANG_W-1:0] al;
		n = (entries_q == '0) ? CNT_W'(1) : entries_q;
		if (n > CNT_W'(SLOTS))
			n = CNT_W'(SLOTS);
		last = LW'(n - CNT_W'(1));
		for (int k = 0; k < SLOTS; k++) begin
			ge[k]   = query_distance >= dist_q[k];
			le[k]   = query_distance <= dist_q[k];
			lsel[k] = last == LW'(k);
		end
		found = 1'b0;
		for (int i = 0; i < SLOTS - 1; i++) begin
			hit[i] = !found && (LW'(i) < last) && ge[i] && le[i+1];
			found  = found || hit[i];
		end
		dl = '0;
		sl = '0;
		al = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (lsel[k]) begin
				dl = dl | dist_q[k];
				sl = sl | spd_q[k];
				al = al | ang_q[k];
			end
		end
		d0_c = '0;
		d1_c = '0;
		v0_c = '0;
		v1_c = '0;
		a0_c = '0;
		a1_c = '0;
		for (int i = 0; i < SLOTS - 1; i++) begin
			if (hit[i]) begin
				d0_c = d0_c | dist_q[i];
				d1_c = d1_c | dist_q[i+1];
				v0_c = v0_c | $signed(VAL_W'(spd_q[i]));
				v1_c = v1_c | $signed(VAL_W'(spd_q[i+1]));
				a0_c = a0_c | VAL_W'(ang_q[i]);
				a1_c = a1_c | VAL_W'(ang_q[i+1]);
			end
		end
		zw         = d0_c == d1_c;
		ctl_c.flag = query_distance > APPLY_DIST;
		ctl_c.direct = 1'b1;
		if (le[0]) begin
			ctl_c.spd = spd_q[0];
			ctl_c.ang = VAL_W'(ang_q[0]);
		end else if (query_distance >= dl) begin
			ctl_c.spd = sl;
			ctl_c.ang = VAL_W'(al);
		end else if (found) begin
			ctl_c.direct = zw;
			ctl_c.spd    = v0_c[SPD_W-1:0];
			ctl_c.ang    = a0_c;
		end else begin
			ctl_c.spd = fallback_q;
			ctl_c.ang = VAL_W'(ang_q[0]);
		end
	end

	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	ctl_t                    ctl_s1, ctl_s2, ctl_s3;
	logic [DIST_W-1:0]       qd_s1, d0_s1, d1_s1;
	logic signed [VAL_W-1:0] v0_s1, v1_s1, a0_s1, a1_s1;
	logic signed [DIF_W-1:0] t_s2, dv_s2, da_s2;
	logic [DIST_W-1:0]       den_s2, den_s3;
	logic signed [VAL_W-1:0] v0_s2, a0_s2;
	logic signed [NUM_W-1:0] pv0_s3, pv1_s3, pa0_s3, pa1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc && !cmd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c;
			qd_s1  <= query_distance;
			d0_s1  <= d0_c;
			d1_s1  <= d1_c;
			v0_s1  <= v0_c;
			v1_s1  <= v1_c;
			a0_s1  <= a0_c;
			a1_s1  <= a1_c;

			ctl_s2 <= ctl_s1;
			t_s2   <= $signed({1'b0, qd_s1 - d0_s1});
			den_s2 <= d1_s1 - d0_s1;
			v0_s2  <= v0_s1;
			a0_s2  <= a0_s1;
			dv_s2  <= DIF_W'(v1_s1) - DIF_W'(v0_s1);
			da_s2  <= DIF_W'(a1_s1) - DIF_W'(a0_s1);

			ctl_s3 <= ctl_s2;
			den_s3 <= den_s2;
			pv0_s3 <= NUM_W'(v0_s2 * $signed({1'b0, den_s2}));
			pv1_s3 <= NUM_W'(t_s2 * dv_s2);
			pa0_s3 <= NUM_W'(a0_s2 * $signed({1'b0, den_s2}));
			pa1_s3 <= NUM_W'(t_s2 * da_s2);
		end
	end

	// Element 0 is the s4 register; element k holds the result of k quotient bits.
	dstage_t                 div_s4 [QUO_W+1];
	logic                    dvld_s4 [QUO_W+1];
	logic signed [NUM_W-1:0] nv_c, na_c;

	assign nv_c = pv0_s3 + pv1_s3;
	assign na_c = pa0_s3 + pa1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s4[0].rem_spd <= nv_c[NUM_W-1] ? MAG_W'(-nv_c) : MAG_W'(nv_c);
			div_s4[0].rem_ang <= na_c[NUM_W-1] ? MAG_W'(-na_c) : MAG_W'(na_c);
			div_s4[0].q_spd   <= '0;
			div_s4[0].q_ang   <= '0;
			div_s4[0].den     <= den_s3;
			div_s4[0].neg_ang <= na_c[NUM_W-1];
			div_s4[0].ctl     <= ctl_s3;
		end
	end
	assign dvld_s4[0] = vld_s4;

	for (genvar k = 1; k <= QUO_W; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvld_s4[k] <= 1'b0;
			else if (adv)
				dvld_s4[k] <= dvld_s4[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv)
				div_s4[k] <= div_step(div_s4[k-1], QUO_W - k);
		end
	end

	dstage_t                 fin;
	logic signed [VAL_W-1:0] ang_c, qa_c, hmin_c, hmax_c;
	logic [SPD_W-1:0]        spd_c;

	assign fin    = div_s4[QUO_W];
	assign hmin_c = VAL_W'(hood_min_q);
	assign hmax_c = VAL_W'(hood_max_q);
	assign qa_c   = fin.neg_ang ? -$signed({1'b0, fin.q_ang}) : $signed({1'b0, fin.q_ang});

	always_comb begin
		logic signed [VAL_W-1:0] a;
		a     = fin.ctl.direct ? fin.ctl.ang : qa_c;
		spd_c = fin.ctl.direct ? fin.ctl.spd : fin.q_spd[SPD_W-1:0];
		if (a < hmin_c)
			ang_c = hmin_c;
		else if (a > hmax_c)
			ang_c = hmax_c;
		else
			ang_c = a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= dvld_s4[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			target_speed <= spd_c;
			target_angle <= ang_c[ANG_W-1:0];
			apply_flag   <= fin.ctl.flag;
		end
	end

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd |=> !vld_s1)
		else $error("write item entered the query pipeline");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s4[QUO_W] && !fin.ctl.direct |->
			fin.rem_spd < MAG_W'(fin.den) && fin.rem_ang < MAG_W'(fin.den))
		else $error("divider remainder not below divisor");

	a_angle_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hood_min_q <= hood_max_q |->
			target_angle >= hood_min_q && target_angle <= hood_max_q)
		else $error("target angle outside hood limits");

	a_flag_follows_query: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !cmd |=> vld_s1 && ctl_s1.flag == (qd_s1 > APPLY_DIST))
		else $error("query lost or flag mismatch at first stage");

endmodule

FILE: test/ballistic_table_interpolator_tb.sv
// ----------------------------------------------------------------------------
// Ballistic table interpolator testbench
// Loads breakpoint tables, sets the configuration registers and sends distance
// queries through the valid/ready channels, with random idling on both sides
// over the first two thirds of the items. An internal interpolator computes
// the expected speed, angle and flag, and each result is compared field by field.
module ballistic_table_interpolator_tb;
	import bti_pkg::*;

	localparam int DEPTH      = 8;
	localparam int SETTLE     = 30;
	localparam int STALL_MAX  = 3000;
	localparam int ITEM_TOTAL = 1300;

	typedef struct {
		logic                    cmd;
		logic [IDX_W-1:0]        idx;
		logic [DIST_W-1:0]       ent_dist;
		logic [SPD_W-1:0]        spd;
		logic signed [ANG_W-1:0] ang;
		logic [DIST_W-1:0]       qd;
	} shot_t;

	typedef struct {
		logic [SPD_W-1:0]        spd;
		logic signed [ANG_W-1:0] ang;
		logic                    flag;
	} aim_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [REG_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    cmd;
	logic [IDX_W-1:0]        entry_index;
	logic [DIST_W-1:0]       entry_distance;
	logic [SPD_W-1:0]        entry_speed;
	logic signed [ANG_W-1:0] entry_angle;
	logic [DIST_W-1:0]       query_distance;
	logic                    out_valid;
	logic                    out_ready;
	logic [SPD_W-1:0]        target_speed;
	logic signed [ANG_W-1:0] target_angle;
	logic                    apply_flag;

	shot_t pending_shots[$];
	aim_t  expected_aims[$];
	shot_t shot_on_bus;

	int  tbl_dist[DEPTH];
	int  tbl_spd[DEPTH];
	int  tbl_ang[DEPTH];
	int  used_entries = 2;
	int  hood_lo = 0;
	int  hood_hi = 9000;
	int  fallback = 0;
	int  accepted = 0;
	int  mismatches = 0;
	int  stall_cycles = 0;
	int  queued = 0;
	bit  took_in, took_out;

	ballistic_table_interpolator #(.TABLE_DEPTH(DEPTH)) i_dut (.*);

	always #5 clk = ~clk;

	function automatic longint lerp_trunc(longint v0, longint v1, longint d, longint d0,
			longint d1);
		return (v0 * (d1 - d0) + (d - d0) * (v1 - v0)) / (d1 - d0);
	endfunction

	function automatic void aim_for(shot_t s);
		int     n, last, qd, d0, d1;
		longint sp, an;
		bit     found;
		aim_t   a;
		if (s.cmd) begin
			tbl_dist[s.idx] = s.ent_dist;
			tbl_spd[s.idx]  = s.spd;
			tbl_ang[s.idx]  = s.ang;
			return;
		end
		qd = s.qd;
		n = used_entries;
		if (n < 1) n = 1;
		if (n > DEPTH) n = DEPTH;
		last = n - 1;
		if (qd <= tbl_dist[0]) begin
			sp = tbl_spd[0];
			an = tbl_ang[0];
		end else if (qd >= tbl_dist[last]) begin
			sp = tbl_spd[last];
			an = tbl_ang[last];
		end else begin
			found = 0;
			sp = fallback;
			an = tbl_ang[0];
			for (int i = 0; i < last && !found; i++) begin
				d0 = tbl_dist[i];
				d1 = tbl_dist[i+1];
				if (qd >= d0 && qd <= d1) begin
					found = 1;
					if (d0 == d1) begin
						sp = tbl_spd[i];
						an = tbl_ang[i];
					end else begin
						sp = lerp_trunc(tbl_spd[i], tbl_spd[i+1], qd, d0, d1);
						an = lerp_trunc(tbl_ang[i], tbl_ang[i+1], qd, d0, d1);
					end
				end
			end
		end
		if (an < hood_lo) an = hood_lo;
		else if (an > hood_hi) an = hood_hi;
		a.spd  = SPD_W'(sp);
		a.ang  = ANG_W'(an);
		a.flag = qd > 500;
		expected_aims.push_back(a);
	endfunction

	function automatic int send_idle_pct();
		if (accepted < ITEM_TOTAL / 3) return 24;
		if (accepted < 2 * ITEM_TOTAL / 3) return 45;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (accepted < ITEM_TOTAL / 3) return 45;
		if (accepted < 2 * ITEM_TOTAL / 3) return 24;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				aim_for(shot_on_bus);
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_shots.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					shot_on_bus = pending_shots.pop_front();
					in_valid       <= 1'b1;
					cmd            <= shot_on_bus.cmd;
					entry_index    <= shot_on_bus.idx;
					entry_distance <= shot_on_bus.ent_dist;
					entry_speed    <= shot_on_bus.spd;
					entry_angle    <= shot_on_bus.ang;
					query_distance <= shot_on_bus.qd;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		aim_t a;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_aims.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: speed %0d angle %0d flag %0d",
							target_speed, target_angle, apply_flag);
				end else begin
					a = expected_aims.pop_front();
					if (a.spd !== target_speed || a.ang !== target_angle
							|| a.flag !== apply_flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								a.spd, a.ang, a.flag, target_speed, target_angle,
								apply_flag);
					end
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle_pct();
		end
	end

	always @(posedge clk) begin
		took_in  = in_valid && in_ready;
		took_out = out_valid && out_ready;
		if (!arst_n || took_in || took_out)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic drain();
		while (pending_shots.size() > 0 || in_valid || expected_aims.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t r, int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= CFG_W'(v);
		case (r)
			REG_ENTRIES:  used_entries = v & 15;
			REG_HOOD_MIN: hood_lo = v;
			REG_HOOD_MAX: hood_hi = v;
			REG_FALLBACK: fallback = v;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_entry(int i, int d, int s, int a);
		shot_t t;
		t = '{cmd: 1'b1, idx: IDX_W'(i), ent_dist: DIST_W'(d), spd: SPD_W'(s),
			ang: ANG_W'(a), qd: DIST_W'($urandom)};
		pending_shots.push_back(t);
		queued++;
	endtask

	task automatic push_query(int q);
		shot_t t;
		t = '{cmd: 1'b0, idx: IDX_W'($urandom), ent_dist: DIST_W'($urandom),
			spd: SPD_W'($urandom), ang: ANG_W'($urandom), qd: DIST_W'(q)};
		pending_shots.push_back(t);
		queued++;
	endtask

	task automatic load_table(bit ordered);
		int d[DEPTH];
		foreach (d[i]) d[i] = $urandom_range(65535);
		if (ordered) begin
			d.sort();
			foreach (d[i]) if (i > 0 && $urandom_range(9) == 0) d[i] = d[i-1];
		end
		foreach (d[i])
			push_entry(i, d[i], $urandom_range(16383), $urandom_range(18000) - 9000);
	endtask

	initial begin
		int n, lo, hi, a, b;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cmd = 0; entry_index = 0; entry_distance = 0; entry_speed = 0;
		entry_angle = 0; query_distance = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		push_entry(0, 100, 0, -9000);
		push_entry(1, 400, 16383, 9000);
		push_entry(2, 400, 500, 100);
		push_entry(3, 1000, 8000, -4000);
		push_entry(4, 5000, 300, 2500);
		push_entry(5, 20000, 12000, -100);
		push_entry(6, 40000, 1, 7000);
		push_entry(7, 65535, 16383, -9000);
		foreach (tbl_dist[i]) begin end
		push_query(0); push_query(100); push_query(250); push_query(400);
		push_query(500); push_query(501); push_query(65535);
		drain();
		set_reg(REG_ENTRIES, 8);
		set_reg(REG_HOOD_MIN, -9000);
		set_reg(REG_HOOD_MAX, 9000);
		set_reg(REG_FALLBACK, 16383);
		push_query(700); push_query(3000); push_query(30000); push_query(65535);
		push_query(401); push_query(65534);
		push_entry(6, 10, 1, 1);
		push_query(50000); push_query(10);
		drain();
		set_reg(REG_HOOD_MIN, 3000);
		set_reg(REG_HOOD_MAX, -3000);
		set_reg(REG_ENTRIES, 0);
		push_query(200); push_query(50);
		drain();

		while (queued < ITEM_TOTAL) begin
			set_reg(REG_ENTRIES, ($urandom_range(9) == 0) ? $urandom_range(15)
				: $urandom_range(8, 1));
			a = $urandom_range(18000) - 9000;
			b = $urandom_range(18000) - 9000;
			if ($urandom_range(4) == 0) begin
				set_reg(REG_HOOD_MIN, a); set_reg(REG_HOOD_MAX, b);
			end else begin
				set_reg(REG_HOOD_MIN, (a < b) ? a : b);
				set_reg(REG_HOOD_MAX, (a < b) ? b : a);
			end
			set_reg(REG_FALLBACK, $urandom_range(16383));
			load_table($urandom_range(4) != 0);
			n = $urandom_range(60, 20);
			repeat (n) begin
				if ($urandom_range(29) == 0) begin
					push_entry($urandom_range(7), $urandom_range(65535),
						$urandom_range(16383), $urandom_range(18000) - 9000);
				end else if ($urandom_range(3) == 0) begin
					push_query($urandom_range(65535));
				end else begin
					lo = tbl_dist[0];
					hi = tbl_dist[DEPTH-1];
					push_query(lo <= hi ? $urandom_range(hi, lo) : $urandom_range(lo, hi));
				end
			end
			drain();
		end

		drain();
		if (mismatches == 0 && expected_aims.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
